[rtl/ffc_pkg.sv]
// Shared types and constants for the flat-field correction block.
// Depends on nothing; imported by the divider and the top level of the block.
package ffc_pkg;

   // Request operation codes
   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_MEASURE = 2'd1;
   localparam logic [1:0] OP_CORRECT = 2'd2;

   // Mode register codes
   localparam logic MODE_AUTO = 1'b0;
   localparam logic MODE_CLIP = 1'b1;

   // Register indexes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FACTOR      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WHITE_WIDTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_X_STEP      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_STEP      = 3'd4;

   // Field widths
   localparam int PIX_W    = 8;
   localparam int FACTOR_W = 16;
   localparam int WWIDTH_W = 9;
   localparam int STEP_W   = 5;
   localparam int PHASE_W  = 4;
   localparam int CNT_W    = 24;
   localparam logic [CNT_W-1:0] CNT_MAX = 24'hFF_FFFF;

   // Divider widths: quotient, dividend, divisor
   localparam int QUO_W = 16;
   localparam int NUM_W = 32;
   localparam int DEN_W = 24;
   localparam int MM_W  = 17;

   // Clip threshold: 2*F*M*P > CLIP_LIMIT*W means value + 0.5 exceeds 255
   localparam int CLIP_LIMIT = 130304;

   // Default frame limits
   localparam int WHITE_MAX_WIDTH_DEF  = 256;
   localparam int WHITE_MAX_HEIGHT_DEF = 256;

   // Sideband that travels with an item through the divider
   typedef struct packed {
      logic measure;    // measure item, else correct item
      logic start;      // first pixel of the pass
      logic wzero;      // reference pixel was zero
      logic clip_mode;  // fixed factor with clipping
      logic clip_over;  // clip-mode threshold exceeded
   } side_type;

endpackage

[rtl/ffc_ram.sv]
// Generic single-port RAM with registered read data.
// Depends on nothing.
module ffc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536,
   parameter int AW    = 16
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic             rd_en,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write or read one entry a cycle; read data holds until the next read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/ffc_divider.sv]
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on ffc_pkg.
module ffc_divider (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic                    in_valid,
   input  ffc_pkg::side_type       in_side,
   input  logic [ffc_pkg::NUM_W-1:0] in_num,
   input  logic [ffc_pkg::DEN_W-1:0] in_den,
   output logic                    out_valid,
   output ffc_pkg::side_type       out_side,
   output logic [ffc_pkg::QUO_W-1:0] out_quo,
   output logic                    out_ovf,
   output logic                    measure_busy
);
   import ffc_pkg::*;

   localparam int STAGES = QUO_W + 1;
   localparam int CMP_W  = DEN_W + QUO_W;

   logic             v_ff    [STAGES];
   side_type         side_ff [STAGES];
   logic [NUM_W-1:0] rem_ff  [STAGES];
   logic [DEN_W-1:0] den_ff  [STAGES];
   logic [QUO_W-1:0] quo_ff  [STAGES];
   logic             ovf_ff  [STAGES];
   logic             ovf_in;

   // Flag a quotient that will not fit in QUO_W bits
   assign ovf_in = CMP_W'(in_num) >= {in_den, QUO_W'(0)};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (enable) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff[0] <= in_side;
         rem_ff[0]  <= in_num;
         den_ff[0]  <= in_den;
         quo_ff[0]  <= '0;
         ovf_ff[0]  <= ovf_in;
      end
   end

   // One compare and subtract per stage, most significant bit first
   for (genvar k = 1; k < STAGES; k++) begin : g_step
      localparam int SH = QUO_W - k;
      logic [CMP_W-1:0] trial;
      logic [CMP_W-1:0] diff;
      logic             take;

      assign trial = CMP_W'(den_ff[k-1]) << SH;
      assign diff  = CMP_W'(rem_ff[k-1]) - trial;
      assign take  = CMP_W'(rem_ff[k-1]) >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (enable) begin
            v_ff[k] <= v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            side_ff[k] <= side_ff[k-1];
            den_ff[k]  <= den_ff[k-1];
            ovf_ff[k]  <= ovf_ff[k-1];
            rem_ff[k]  <= take ? diff[NUM_W-1:0] : rem_ff[k-1];
            quo_ff[k]  <= quo_ff[k-1] | (QUO_W'(take) << SH);
         end
      end
   end

   // Report any measure item still in flight
   always_comb begin
      measure_busy = 1'b0;
      for (int s = 0; s < STAGES; s++) begin
         measure_busy = measure_busy | (v_ff[s] & side_ff[s].measure);
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];
   assign out_quo   = quo_ff[STAGES-1];
   assign out_ovf   = ovf_ff[STAGES-1];
endmodule

[rtl/flat_field_light_correction.sv]
// Top level of the flat-field correction block: registers, reference store,
// positions, operand stages and result stage. Depends on ffc_pkg, ffc_ram,
// ffc_divider.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | operation, pixel, frame_start
//  rsp     | out       | rsp_valid/rsp_stall | corrected, clipped, white_zero, clip_count
//  csr     | in        | csr_write           | csr_index, csr_data
//
// One request per cycle while req_stall is low; a correct response passes through three
// operand stages, one range check, sixteen divider stages and the output register.
// Load and measure requests give no response. A correct request waits at the input
// while a measure request is still in the pipeline, since it needs the measured maximum.
// A stalled response freezes the whole pipeline. Reset is synchronous; the reference
// store is not cleared and must be loaded before it is read.
module flat_field_light_correction #(
   parameter int WHITE_MAX_WIDTH  = ffc_pkg::WHITE_MAX_WIDTH_DEF,
   parameter int WHITE_MAX_HEIGHT = ffc_pkg::WHITE_MAX_HEIGHT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_operation,
   input  logic [ffc_pkg::PIX_W-1:0]      req_pixel,
   input  logic                           req_frame_start,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ffc_pkg::PIX_W-1:0]      rsp_corrected,
   output logic                           rsp_clipped,
   output logic                           rsp_white_zero,
   output logic [ffc_pkg::CNT_W-1:0]      rsp_clip_count,
   input  logic                           csr_write,
   input  logic [ffc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ffc_pkg::CSR_DATA_W-1:0] csr_data
);
   import ffc_pkg::*;

   localparam int STORE = WHITE_MAX_WIDTH * WHITE_MAX_HEIGHT;
   localparam int AW    = (STORE > 1) ? $clog2(STORE) : 1;
   localparam int CW    = (WHITE_MAX_WIDTH > 1) ? $clog2(WHITE_MAX_WIDTH) : 1;
   localparam int RW    = (WHITE_MAX_HEIGHT > 1) ? $clog2(WHITE_MAX_HEIGHT) : 1;
   localparam int WWB   = $clog2(WHITE_MAX_WIDTH + 1);

   // Configuration registers
   logic                mode_ff;
   logic [FACTOR_W-1:0] factor_ff;
   logic [WWIDTH_W-1:0] white_width_ff;
   logic [STEP_W-1:0]   x_step_ff;
   logic [STEP_W-1:0]   y_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_CLIP;
         factor_ff      <= 16'd256;
         white_width_ff <= 9'd256;
         x_step_ff      <= 5'd1;
         y_step_ff      <= 5'd1;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MODE:        mode_ff        <= csr_data[0];
            CSR_FACTOR:      factor_ff      <= csr_data;
            CSR_WHITE_WIDTH: white_width_ff <= csr_data[WWIDTH_W-1:0];
            CSR_X_STEP:      x_step_ff      <= csr_data[STEP_W-1:0];
            CSR_Y_STEP:      y_step_ff      <= csr_data[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp geometry registers into their legal ranges
   logic [WWB-1:0]    ww;
   logic [STEP_W-1:0] xs;
   logic [STEP_W-1:0] ys;

   always_comb begin
      if (white_width_ff == '0) begin
         ww = WWB'(1);
      end else if (32'(white_width_ff) > 32'(WHITE_MAX_WIDTH)) begin
         ww = WWB'(WHITE_MAX_WIDTH);
      end else begin
         ww = WWB'(white_width_ff);
      end
      if (x_step_ff == '0) begin
         xs = 5'd1;
      end else if (x_step_ff > 5'd16) begin
         xs = 5'd16;
      end else begin
         xs = x_step_ff;
      end
      if (y_step_ff == '0) begin
         ys = 5'd1;
      end else if (y_step_ff > 5'd16) begin
         ys = 5'd16;
      end else begin
         ys = y_step_ff;
      end
   end

   // Pipeline advance and request acceptance
   logic enable;
   logic measure_busy;
   logic meas_busy;
   logic accept;
   logic is_load;
   logic is_image;

   assign enable    = !rsp_valid || !rsp_stall;
   assign req_stall = !enable || (req_operation == OP_CORRECT && meas_busy);
   assign accept    = req_valid && !req_stall;
   assign is_load   = req_operation == OP_LOAD;
   assign is_image  = req_operation == OP_MEASURE || req_operation == OP_CORRECT;

   // Load address and reference maximum
   logic [AW-1:0]    load_addr_ff;
   logic [AW-1:0]    load_addr_cur;
   logic [AW-1:0]    load_addr_in;
   logic [PIX_W-1:0] white_max_ff;
   logic [PIX_W-1:0] white_max_base;
   logic [PIX_W-1:0] white_max_in;

   assign load_addr_cur  = req_frame_start ? '0 : load_addr_ff;
   assign load_addr_in   = (load_addr_cur == AW'(STORE - 1)) ? '0 : load_addr_cur + 1'b1;
   assign white_max_base = req_frame_start ? '0 : white_max_ff;
   assign white_max_in   = (req_pixel > white_max_base) ? req_pixel : white_max_base;

   always_ff @(posedge clock) begin
      if (reset) begin
         load_addr_ff <= '0;
         white_max_ff <= '0;
      end else if (accept && is_load) begin
         load_addr_ff <= load_addr_in;
         white_max_ff <= white_max_in;
      end
   end

   // Image positions: current place, reference address and next place
   logic [CW-1:0]      col_ff, col_cur, col_in;
   logic [RW-1:0]      row_ff, row_cur, row_in;
   logic [PHASE_W-1:0] xp_ff, xp_cur, xp_in;
   logic [PHASE_W-1:0] yp_ff, yp_cur, yp_in;
   logic [31:0]        addr_wide;
   logic [AW-1:0]      white_addr;
   logic [STEP_W-1:0]  xp_inc, yp_inc;
   logic [WWB-1:0]     col_inc;

   assign col_cur    = req_frame_start ? '0 : col_ff;
   assign row_cur    = req_frame_start ? '0 : row_ff;
   assign xp_cur     = req_frame_start ? '0 : xp_ff;
   assign yp_cur     = req_frame_start ? '0 : yp_ff;
   assign addr_wide  = 32'(row_cur) * 32'(ww) + 32'(col_cur);
   assign white_addr = addr_wide[AW-1:0];
   assign xp_inc     = STEP_W'(xp_cur) + 1'b1;
   assign yp_inc     = STEP_W'(yp_cur) + 1'b1;
   assign col_inc    = WWB'(col_cur) + 1'b1;

   always_comb begin
      col_in = col_cur;
      row_in = row_cur;
      xp_in  = xp_inc[PHASE_W-1:0];
      yp_in  = yp_cur;
      if (xp_inc >= xs) begin
         xp_in = '0;
         col_in = col_inc[CW-1:0];
         if (col_inc >= ww) begin
            col_in = '0;
            yp_in  = yp_inc[PHASE_W-1:0];
            if (yp_inc >= ys) begin
               yp_in  = '0;
               row_in = (row_cur == RW'(WHITE_MAX_HEIGHT - 1)) ? '0 : row_cur + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         xp_ff  <= '0;
         yp_ff  <= '0;
      end else if (accept && is_image) begin
         col_ff <= col_in;
         row_ff <= row_in;
         xp_ff  <= xp_in;
         yp_ff  <= yp_in;
      end
   end

   // Reference store: load writes, measure and correct read
   logic [PIX_W-1:0] white_rd;

   ffc_ram #(
      .WIDTH (PIX_W),
      .DEPTH (STORE),
      .AW    (AW)
   ) u_white (
      .clock   (clock),
      .wr_en   (accept && is_load),
      .rd_en   (accept && is_image),
      .addr    (is_load ? load_addr_cur : white_addr),
      .wr_data (req_pixel),
      .rd_data (white_rd)
   );

   // Stage 1: reference pixel arrives, form white_max * pixel
   logic             v1_ff;
   logic             meas1_ff;
   logic             start1_ff;
   logic [PIX_W-1:0] p1_ff;
   logic [15:0]      mp1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= accept && is_image;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         meas1_ff  <= req_operation == OP_MEASURE;
         start1_ff <= req_frame_start;
         p1_ff     <= req_pixel;
      end
   end

   assign mp1 = 16'(white_max_ff) * 16'(p1_ff);

   // Stage 2: scale products and the rescale divisor
   logic              v2_ff;
   side_type          side2_ff;
   logic [PIX_W-1:0]  w2_ff;
   logic [15:0]       mp2_ff;
   logic signed [MM_W-1:0] mm_ff;
   logic [NUM_W-1:0]  prod_f;
   logic [DEN_W-1:0]  prod_d;
   logic [DEN_W-1:0]  mp255;
   logic              clip_sel2;
   logic              big_sel2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (enable) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side2_ff <= '{measure: meas1_ff, start: start1_ff, wzero: white_rd == '0,
                       clip_mode: 1'b0, clip_over: 1'b0};
         w2_ff    <= white_rd;
         mp2_ff   <= mp1;
      end
   end

   assign prod_f    = NUM_W'(factor_ff) * NUM_W'(mp2_ff);
   assign prod_d    = DEN_W'(mm_ff[15:0]) * DEN_W'(w2_ff);
   assign mp255     = {mp2_ff, 8'd0} - DEN_W'(mp2_ff);
   assign clip_sel2 = !side2_ff.measure && mode_ff == MODE_CLIP;
   assign big_sel2  = !side2_ff.measure && mode_ff == MODE_AUTO
                      && !mm_ff[MM_W-1] && mm_ff[15:8] != '0;

   // Stage 3: dividend, divisor and clip threshold
   logic              v3_ff;
   side_type          side3_ff;
   logic              big3_ff;
   logic [NUM_W-1:0]  num3_ff;
   logic [DEN_W-1:0]  d3_ff;
   logic [PIX_W-1:0]  w3_ff;
   logic [15:0]       mp3_ff;
   logic [NUM_W-1:0]  div_num;
   logic [DEN_W-1:0]  div_den;
   side_type          side3;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (enable) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side3_ff <= '{measure: side2_ff.measure, start: side2_ff.start,
                       wzero: side2_ff.wzero, clip_mode: clip_sel2, clip_over: 1'b0};
         big3_ff  <= big_sel2;
         num3_ff  <= clip_sel2 ? prod_f : NUM_W'(mp255);
         d3_ff    <= prod_d;
         w3_ff    <= w2_ff;
         mp3_ff   <= mp2_ff;
      end
   end

   // Hold correct requests while a measure is anywhere ahead of the commit
   assign meas_busy = measure_busy || (v1_ff && meas1_ff) || (v2_ff && side2_ff.measure)
                      || (v3_ff && side3_ff.measure);

   always_comb begin
      side3 = side3_ff;
      if (side3_ff.clip_mode) begin
         div_num = num3_ff + NUM_W'({w3_ff, 7'd0});
         div_den = DEN_W'({w3_ff, 8'd0});
         side3.clip_over = {num3_ff, 1'b0} > 33'(CLIP_LIMIT) * 33'(w3_ff);
      end else if (big3_ff) begin
         div_num = num3_ff + NUM_W'(d3_ff >> 1);
         div_den = d3_ff;
      end else begin
         div_num = NUM_W'(mp3_ff) + NUM_W'(w3_ff >> 1);
         div_den = DEN_W'(w3_ff);
      end
   end

   // Divide
   logic             dv;
   side_type         dside;
   logic [QUO_W-1:0] dquo;
   logic             dovf;

   ffc_divider u_div (
      .clock        (clock),
      .reset        (reset),
      .enable       (enable),
      .in_valid     (v3_ff),
      .in_side      (side3),
      .in_num       (div_num),
      .in_den       (div_den),
      .out_valid    (dv),
      .out_side     (dside),
      .out_quo      (dquo),
      .out_ovf      (dovf),
      .measure_busy (measure_busy)
   );

   // Result stage: measured maximum, clip decision and clip counter
   logic signed [MM_W-1:0] mm_in;
   logic signed [MM_W-1:0] t_quo;
   logic [PIX_W-1:0]       res;
   logic                   clip;
   logic [CNT_W-1:0]       cnt_ff;
   logic [CNT_W-1:0]       cnt_base;
   logic [CNT_W-1:0]       cnt_in;
   logic                   commit_meas;
   logic                   commit_corr;

   assign t_quo       = $signed({1'b0, dquo});
   assign commit_meas = enable && dv && dside.measure;
   assign commit_corr = enable && dv && !dside.measure;

   always_comb begin
      if (dside.start) begin
         mm_in = dside.wzero ? -17'sd1 : t_quo;
      end else if (!dside.wzero && t_quo > mm_ff) begin
         mm_in = t_quo;
      end else begin
         mm_in = mm_ff;
      end
   end

   always_comb begin
      clip = 1'b0;
      res  = dquo[PIX_W-1:0];
      if (dside.wzero) begin
         res = 8'hFF;
      end else if (dside.clip_mode) begin
         clip = dside.clip_over;
         if (dside.clip_over || dquo[15:8] != '0) begin
            res = 8'hFF;
         end
      end else if (dovf || dquo[15:8] != '0) begin
         clip = 1'b1;
         res  = 8'hFF;
      end
   end

   assign cnt_base = dside.start ? '0 : cnt_ff;
   assign cnt_in   = (clip && cnt_base != CNT_MAX) ? cnt_base + 1'b1 : cnt_base;

   always_ff @(posedge clock) begin
      if (reset) begin
         mm_ff  <= -17'sd1;
         cnt_ff <= '0;
      end else begin
         if (commit_meas) begin
            mm_ff <= mm_in;
         end
         if (commit_corr) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   // Output register: hold while the response is stalled
   logic             rsp_valid_ff;
   logic [PIX_W-1:0] corrected_ff;
   logic             clipped_ff;
   logic             wzero_ff;
   logic [CNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= dv && !dside.measure;
      end
   end

   always_ff @(posedge clock) begin
      if (commit_corr) begin
         corrected_ff <= res;
         clipped_ff   <= clip;
         wzero_ff     <= dside.wzero;
         count_ff     <= cnt_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_corrected  = corrected_ff;
   assign rsp_clipped    = clipped_ff;
   assign rsp_white_zero = wzero_ff;
   assign rsp_clip_count = count_ff;

`ifndef SYNTH
   // A zero reference forces full scale and is never counted as clipped
   a_wzero_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_white_zero |-> rsp_corrected == 8'hFF && !rsp_clipped)
      else $error("zero reference response not forced to full scale");

   // A clipped response is always included in the count
   a_clip_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |-> rsp_clip_count != '0)
      else $error("clipped response with zero clip count");

   // The measured maximum never drops below minus one
   a_mm_floor: assert property (@(posedge clock) disable iff (reset)
      mm_ff >= -17'sd1)
      else $error("measured maximum below minus one");

   // A correct request never enters behind an uncommitted measure
   a_no_overtake: assert property (@(posedge clock) disable iff (reset)
      v1_ff && !meas1_ff && $past(enable) |-> !$past(meas_busy))
      else $error("correct request entered while a measure was in flight");

   // A frozen pipeline keeps the divider output
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !enable |=> $stable(dv) && $stable(dquo))
      else $error("divider output moved while frozen");
`endif
endmodule
